### design/pscm_pkg.sv
// ----------------------------------------------------------------------------
// pscm_pkg: shared types and constants of the prime sieve counter
// Field widths of the stream payloads and the fixed values that seed the sieve.
// ----------------------------------------------------------------------------
package pscm_pkg;

	localparam int unsigned FIELD_W     = 17;
	localparam int unsigned IN_TDATA_W  = 24;
	localparam int unsigned OUT_TDATA_W = 40;

	// the wheel strikes 2, 3, 5 and 7; the sieve proper starts at 11
	localparam int unsigned MIN_LIMIT     = 7;
	localparam int unsigned SMALL_PRIMES  = 4;
	localparam int unsigned LARGEST_SMALL = 7;
	localparam int unsigned FIRST_SIEVE   = 11;
	localparam int unsigned FIRST_SQUARE  = 121;

	typedef struct packed {
		logic [FIELD_W-1:0] largest_prime;
		logic [FIELD_W-1:0] prime_count;
	} result_t;

endpackage

### design/prime_sieve_count_max.sv
// ----------------------------------------------------------------------------
// prime_sieve_count_max: prime counter and largest-prime finder
// Sieve of Eratosthenes over an on-chip bitmap for each requested limit.
// ----------------------------------------------------------------------------
//  channel   dir  payload (low bit up)                      transfer when
//  s_axis    in   limit[16:0]                               tvalid & tready
//  m_axis    out  prime_count[16:0], largest_prime[33:17]   tvalid & tready
//
// One request at a time; a request with limit N (clamped to 7..MAX_LIMIT)
// clears the bitmap over 0..N, reads each candidate from 11 up to sqrt(N),
// strikes the multiples of each sieving prime from its square, then scans
// 11..N; the bitmap RAM has a single write port and a single read port.
// The result sits in an output register, so the next request is taken while
// it waits. Reset clears control state only; the bitmap is rewritten per request.
module prime_sieve_count_max #(
	parameter int unsigned MAX_LIMIT = 65536
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [pscm_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // limit
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [pscm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata   // prime_count, largest_prime
);

	localparam int unsigned DEPTH = MAX_LIMIT + 1;
	localparam int unsigned AW    = $clog2(DEPTH);

	logic                 res_valid;
	logic                 res_ready;
	pscm_pkg::result_t    res;
	logic                 we;
	logic [AW-1:0]        waddr;
	logic                 wdata;
	logic [AW-1:0]        raddr;
	logic                 rdata;
	logic                 out_valid_q;
	pscm_pkg::result_t    out_res_q;

	pscm_ctrl #(
		.MAX_LIMIT (MAX_LIMIT),
		.AW        (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_limit  (s_axis_tdata[pscm_pkg::FIELD_W-1:0]),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.we        (we),
		.waddr     (waddr),
		.wdata     (wdata),
		.raddr     (raddr),
		.rdata     (rdata)
	);

	pscm_map #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_map (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// hold the result until the downstream transfer completes
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = pscm_pkg::OUT_TDATA_W'(out_res_q);

endmodule

### design/pscm_map.sv
// ----------------------------------------------------------------------------
// pscm_map: struck-candidate bitmap
// One-bit-wide synchronous RAM, one write port and one read port with a
// registered read.
// ----------------------------------------------------------------------------
module pscm_map #(
	parameter int unsigned DEPTH = 65537,
	parameter int unsigned AW    = 17
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic          wdata,
	input  logic [AW-1:0] raddr,
	output logic          rdata
);

	logic mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### design/pscm_ctrl.sv
// ----------------------------------------------------------------------------
// pscm_ctrl: sieve sequencer
// Clears the bitmap with the 2-3-5-7 wheel applied, strikes multiples of each
// surviving candidate up to the square root, then scans for count and maximum.
// ----------------------------------------------------------------------------
module pscm_ctrl #(
	parameter int unsigned MAX_LIMIT = 65536,
	parameter int unsigned AW        = 17
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [pscm_pkg::FIELD_W-1:0]    in_limit,
	output logic                            res_valid,
	input  logic                            res_ready,
	output pscm_pkg::result_t               res,
	output logic                            we,
	output logic [AW-1:0]                   waddr,
	output logic                            wdata,
	output logic [AW-1:0]                   raddr,
	input  logic                            rdata
);

	localparam int unsigned CW_RAW = (AW + 1) / 2 + 1;
	localparam int unsigned CW     = (CW_RAW > 4) ? CW_RAW : 4;
	localparam int unsigned MW     = AW + 1;
	localparam int unsigned SW     = (2 * CW > MW) ? 2 * CW : MW;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_CLEAR  = 7'b0000010,
		ST_CHECK  = 7'b0000100,
		ST_TEST   = 7'b0001000,
		ST_STRIKE = 7'b0010000,
		ST_SCAN   = 7'b0100000,
		ST_FIN    = 7'b1000000
	} state_t;

	state_t          state_q;
	logic [AW-1:0]   n_q;
	logic [SW-1:0]   m_q;
	logic [CW-1:0]   c_q;
	logic [SW-1:0]   sq_q;
	logic            r2_q;
	logic [1:0]      r3_q;
	logic [2:0]      r5_q;
	logic [2:0]      r7_q;
	logic [AW-1:0]   count_q;
	logic [AW-1:0]   largest_q;
	logic            valid_s1;
	logic [AW-1:0]   addr_s1;

	logic [SW-1:0]   n_ext;
	logic [31:0]     limit_w;
	logic [31:0]     n_next;
	logic            m_in_range;

	assign n_ext      = SW'(n_q);
	assign m_in_range = (m_q <= n_ext);
	assign limit_w    = 32'(in_limit);

	always_comb begin
		priority if (limit_w < pscm_pkg::MIN_LIMIT) begin
			n_next = pscm_pkg::MIN_LIMIT;
		end else if (limit_w > MAX_LIMIT) begin
			n_next = MAX_LIMIT;
		end else begin
			n_next = limit_w;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_FIN);
	assign res.prime_count   = pscm_pkg::FIELD_W'(count_q);
	assign res.largest_prime = pscm_pkg::FIELD_W'(largest_q);

	// clear pass writes the wheel pattern directly: 0, 1 and multiples of 2,3,5,7
	always_comb begin
		we    = 1'b0;
		wdata = 1'b1;
		waddr = AW'(m_q);
		raddr = AW'(m_q);
		unique case (state_q)
			ST_CLEAR: begin
				we    = 1'b1;
				wdata = (m_q[SW-1:1] == '0) || !r2_q || (r3_q == 2'd0)
					|| (r5_q == 3'd0) || (r7_q == 3'd0);
			end
			ST_STRIKE: begin
				we = m_in_range;
			end
			ST_CHECK: begin
				raddr = AW'(c_q);
			end
			ST_IDLE, ST_TEST, ST_SCAN, ST_FIN: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (state_q == ST_SCAN) && m_in_range;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_CLEAR;
					end
				end
				ST_CLEAR: begin
					if (m_q == n_ext) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					state_q <= (sq_q > n_ext) ? ST_SCAN : ST_TEST;
				end
				ST_TEST: begin
					state_q <= rdata ? ST_CHECK : ST_STRIKE;
				end
				ST_STRIKE: begin
					if (!m_in_range) begin
						state_q <= ST_CHECK;
					end
				end
				ST_SCAN: begin
					if (!m_in_range) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= AW'(m_q);
		if (valid_s1 && !rdata) begin
			count_q   <= count_q + AW'(1);
			largest_q <= addr_s1;
		end
		unique case (state_q)
			ST_IDLE: begin
				n_q  <= AW'(n_next);
				m_q  <= '0;
				r2_q <= 1'b0;
				r3_q <= 2'd0;
				r5_q <= 3'd0;
				r7_q <= 3'd0;
			end
			ST_CLEAR: begin
				m_q  <= m_q + SW'(1);
				r2_q <= ~r2_q;
				r3_q <= (r3_q == 2'd2) ? 2'd0 : r3_q + 2'd1;
				r5_q <= (r5_q == 3'd4) ? 3'd0 : r5_q + 3'd1;
				r7_q <= (r7_q == 3'd6) ? 3'd0 : r7_q + 3'd1;
				c_q  <= CW'(pscm_pkg::FIRST_SIEVE);
				sq_q <= SW'(pscm_pkg::FIRST_SQUARE);
			end
			ST_CHECK: begin
				m_q       <= SW'(pscm_pkg::FIRST_SIEVE);
				count_q   <= AW'(pscm_pkg::SMALL_PRIMES);
				largest_q <= AW'(pscm_pkg::LARGEST_SMALL);
			end
			ST_TEST: begin
				if (rdata) begin
					c_q  <= c_q + CW'(1);
					sq_q <= sq_q + SW'({c_q, 1'b1});
				end else begin
					m_q <= sq_q;
				end
			end
			ST_STRIKE: begin
				if (m_in_range) begin
					m_q <= m_q + SW'(c_q);
				end else begin
					// advance to next candidate, (c+1)^2 = c^2 + 2c + 1
					c_q  <= c_q + CW'(1);
					sq_q <= sq_q + SW'({c_q, 1'b1});
				end
			end
			ST_SCAN: begin
				if (m_in_range) begin
					m_q <= m_q + SW'(1);
				end
			end
			ST_FIN: begin
			end
			default: begin
			end
		endcase
	end

	a_accept_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_CLEAR))
		else $error("accepted transfer did not start the clear pass");

	a_strike_above_square: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STRIKE && we) |-> (m_q >= sq_q))
		else $error("strike below square of the candidate");

	a_test_after_check: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TEST) |-> ($past(state_q) == ST_CHECK))
		else $error("candidate tested without a read");

	a_no_write_while_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || valid_s1) |-> !we)
		else $error("bitmap written during the scan");

endmodule
